/* design/sobol_pkg.sv */
package sobol_pkg;

  // Default configuration of the generator.
  localparam int unsigned MAX_DIMS_DEF      = 18;
  localparam int unsigned FRACTION_BITS_DEF = 32;

  // Size of the built-in polynomial tables and the widest polynomial degree.
  localparam int unsigned TABLE_DIMS = 18;
  localparam int unsigned MAX_DEGREE = 6;
  localparam int unsigned INIT_DIMS  = 7;

  // Point counter width and reset value of the dimension register.
  localparam int unsigned CNT_W      = 33;
  localparam logic [4:0]  DIMS_RESET = 5'd18;

  // Item actions.
  localparam logic ACT_NEXT = 1'b0;
  localparam logic ACT_SEEK = 1'b1;

  localparam logic [2:0] POLY_DEGREE [TABLE_DIMS] =
      '{3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6};

  localparam logic [4:0] POLY_TAPS [TABLE_DIMS] =
      '{5'd0, 5'd1, 5'd1, 5'd2, 5'd1, 5'd4, 5'd2, 5'd4, 5'd7,
        5'd11, 5'd13, 5'd14, 5'd1, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25};

  localparam logic [2:0] INIT_SECOND [INIT_DIMS] =
      '{3'd3, 3'd1, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1};

  localparam logic [2:0] INIT_THIRD [INIT_DIMS] =
      '{3'd5, 3'd7, 3'd7, 3'd3, 3'd3, 3'd5, 3'd1};

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_POINT,
    ST_SEEK,
    ST_EXH
  } sobol_state_e;

  // Initial odd multiplier for a given dimension and 1-based row.
  function automatic logic [2:0] start_value(input logic [4:0] dim, input logic [2:0] row);
    logic [2:0] val;
    val = 3'd1;
    if (dim < 5'(INIT_DIMS)) begin
      if (row == 3'd2) begin
        val = INIT_SECOND[dim[2:0]];
      end else if (row == 3'd3) begin
        val = INIT_THIRD[dim[2:0]];
      end
    end
    return val;
  endfunction

endpackage

/* design/sobol_item_if.sv */
interface sobol_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seek_index;

  modport source (output valid, output action, output seek_index, input ready);
  modport sink (input valid, input action, input seek_index, output ready);
endinterface

/* design/sobol_result_if.sv */
interface sobol_result_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dimension;
  logic [31:0] coordinate;
  logic        last;
  logic        exhausted;

  modport source (output valid, output dimension, output coordinate, output last,
                  output exhausted, input ready);
  modport sink (input valid, input dimension, input coordinate, input last,
                input exhausted, output ready);
endinterface

/* design/sobol_sequence_generator.sv */
// Sobol quasi-random point generator (Gray-code update).
// The item channel carries an action and a seek index. A next-point item
// advances the sequence by one point and produces one result beat per
// dimension in use, dimension 0 first, with last set on the final beat.
// A seek item loads the point counter and rebuilds every coordinate from the
// Gray code of the index; it produces no beat. When the counter has run out,
// a next-point item produces a single beat with exhausted and last set.
// The configuration port writes the dimension count; 0 acts as 1 and values
// above MAX_DIMS act as MAX_DIMS. Write it only while the block is idle.
// After reset the block builds its direction-number memory and clears the
// coordinates, one memory word per cycle, with the item channel held not
// ready.
// One item is in work at a time. A point does one coordinate read-modify-write
// per cycle while the receiver takes beats; a seek does one direction-number
// read per cycle. Results leave through an output register, so a stalled
// receiver holds the current beat and pauses the coordinate pipeline without
// losing anything.
module sobol_sequence_generator import sobol_pkg::*; #(
  parameter int unsigned MAX_DIMS      = MAX_DIMS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [4:0]            cfg_wdata_i,
  sobol_item_if.sink            item_i,
  sobol_result_if.source        result_o
);

  localparam int unsigned FB     = FRACTION_BITS;
  localparam int unsigned DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned ROW_W  = $clog2(FB);
  localparam int unsigned DN_DEPTH = MAX_DIMS * FB;
  localparam int unsigned DN_AW  = $clog2(DN_DEPTH);
  localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MAX_DIMS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FB - 1);

  sobol_state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [4:0]       dims_q, dims_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] dim_q, dim_d;
  logic             iss_done_q, iss_done_d;
  logic [DN_AW-1:0] dn_addr_q, dn_addr_d;
  logic             s2_valid_q, s2_valid_d;
  logic [DIM_W-1:0] s2_dim_q, s2_dim_d;
  logic             s2_bit_q, s2_bit_d;
  logic             s2_last_row_q, s2_last_row_d;
  logic [FB-1:0]    acc_q, acc_d;
  logic [FB-1:0]    gray_q, gray_d;
  logic [FB-1:0]    win_q [MAX_DEGREE];
  logic [FB-1:0]    win_d [MAX_DEGREE];

  logic             out_valid_q, out_valid_d;
  logic [4:0]       out_dim_q, out_dim_d;
  logic [31:0]      out_coord_q, out_coord_d;
  logic             out_last_q, out_last_d;
  logic             out_exh_q, out_exh_d;

  // Memory ports.
  logic             dn_we, dn_re;
  logic [FB-1:0]    dn_wdata, dn_rdata;
  logic             co_we, co_re;
  logic [DIM_W-1:0] co_waddr;
  logic [FB-1:0]    co_wdata, co_rdata;

  // Lowest zero bit of the counter and the active dimension count.
  logic [CNT_W:0]   cnt_ext, zero_onehot;
  logic [5:0]       zero_pos;
  logic             cnt_exhausted;
  logic [4:0]       n_act;

  logic [4:0]       dim5;
  logic [2:0]       deg;
  logic [4:0]       taps;
  logic [6:0]       jrow;
  logic [FB-1:0]    fill_val;

  logic [63:0]      gray64;
  logic [FB-1:0]    xor_val, seek_val;
  logic [63:0]      xor64;
  logic             out_free, s2_emit, s2_last, s2_move, can_issue;

  sobol_ram #(.WIDTH(FB), .DEPTH(DN_DEPTH)) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (dn_we),
    .waddr_i(dn_addr_q),
    .wdata_i(dn_wdata),
    .re_i   (dn_re),
    .raddr_i(dn_addr_q),
    .rdata_o(dn_rdata)
  );

  sobol_ram #(.WIDTH(FB), .DEPTH(MAX_DIMS)) u_coord_ram (
    .clk_i  (clk_i),
    .we_i   (co_we),
    .waddr_i(co_waddr),
    .wdata_i(co_wdata),
    .re_i   (co_re),
    .raddr_i(dim_q),
    .rdata_o(co_rdata)
  );

  // The lowest zero bit of the counter is the only set bit of ~c & (c + 1).
  // A position at or beyond the fraction width means the sequence has run out.
  always_comb begin
    cnt_ext     = {1'b0, cnt_q};
    zero_onehot = ~cnt_ext & (cnt_ext + 1'b1);
    zero_pos    = '0;
    for (int i = 0; i <= CNT_W; i++) begin
      if (zero_onehot[i]) begin
        zero_pos = zero_pos | 6'(i);
      end
    end
    cnt_exhausted = (7'(zero_pos) >= 7'(FB));
  end

  always_comb begin
    if (dims_q == 5'd0) begin
      n_act = 5'd1;
    end else if (dims_q > 5'(MAX_DIMS)) begin
      n_act = 5'(MAX_DIMS);
    end else begin
      n_act = dims_q;
    end
  end

  // Direction-number recurrence used while the memory is built. The window
  // holds the previous rows of the current dimension, newest first.
  always_comb begin
    logic [2:0] sh;
    dim5     = 5'(dim_q);
    deg      = POLY_DEGREE[dim5];
    taps     = POLY_TAPS[dim5];
    jrow     = 7'(row_q) + 7'd1;
    fill_val = '0;
    sh       = '0;
    if (jrow <= 7'(deg)) begin
      fill_val = FB'(start_value(dim5, jrow[2:0])) << (7'(FB) - jrow);
    end else begin
      for (int l = 1; l <= MAX_DEGREE; l++) begin
        if (3'(l) == deg) begin
          fill_val = fill_val ^ win_q[l-1] ^ (win_q[l-1] >> l);
        end else if (3'(l) < deg) begin
          sh = deg - 3'(l) - 3'd1;
          if (((taps >> sh) & 5'd1) != 5'd0) begin
            fill_val = fill_val ^ win_q[l-1];
          end
        end
      end
    end
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign out_free     = !out_valid_q || result_o.ready;

  always_comb begin
    gray64   = {32'd0, item_i.seek_index ^ (item_i.seek_index >> 1)};
    xor_val  = co_rdata ^ dn_rdata;
    xor64    = 64'(xor_val);
    seek_val = acc_q ^ (dn_rdata & {FB{s2_bit_q}});
    s2_emit  = (5'(s2_dim_q) < n_act);
    s2_last  = (5'(s2_dim_q) + 5'd1 == n_act);
    s2_move  = s2_valid_q && (!s2_emit || out_free);
    can_issue = !iss_done_q && (!s2_valid_q || s2_move);
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    dims_d        = dims_q;
    row_d         = row_q;
    dim_d         = dim_q;
    iss_done_d    = iss_done_q;
    dn_addr_d     = dn_addr_q;
    s2_valid_d    = s2_valid_q;
    s2_dim_d      = s2_dim_q;
    s2_bit_d      = s2_bit_q;
    s2_last_row_d = s2_last_row_q;
    acc_d         = acc_q;
    gray_d        = gray_q;
    win_d         = win_q;
    dn_we         = 1'b0;
    dn_re         = 1'b0;
    dn_wdata      = fill_val;
    co_we         = 1'b0;
    co_re         = 1'b0;
    co_waddr      = s2_dim_q;
    co_wdata      = xor_val;
    out_dim_d     = out_dim_q;
    out_coord_d   = out_coord_q;
    out_last_d    = out_last_q;
    out_exh_d     = out_exh_q;
    out_valid_d   = out_valid_q && !result_o.ready;

    if (cfg_we_i) begin
      dims_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_FILL: begin
        dn_we    = 1'b1;
        win_d[0] = fill_val;
        for (int i = 1; i < MAX_DEGREE; i++) begin
          win_d[i] = win_q[i-1];
        end
        if (row_q == '0) begin
          co_we    = 1'b1;
          co_waddr = dim_q;
          co_wdata = '0;
        end
        dn_addr_d = dn_addr_q + 1'b1;
        if (row_q == ROW_LAST) begin
          row_d = '0;
          if (dim_q == DIM_LAST) begin
            state_d = ST_IDLE;
          end else begin
            dim_d = dim_q + 1'b1;
          end
        end else begin
          row_d = row_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (item_i.valid) begin
          dim_d      = '0;
          iss_done_d = 1'b0;
          s2_valid_d = 1'b0;
          if (item_i.action == ACT_SEEK) begin
            cnt_d     = {1'b0, item_i.seek_index};
            gray_d    = gray64[FB-1:0];
            acc_d     = '0;
            row_d     = '0;
            dn_addr_d = '0;
            state_d   = ST_SEEK;
          end else if (cnt_exhausted) begin
            state_d = ST_EXH;
          end else begin
            cnt_d     = cnt_q + 1'b1;
            row_d     = ROW_W'(zero_pos);
            dn_addr_d = DN_AW'(zero_pos);
            state_d   = ST_POINT;
          end
        end
      end

      // Read coordinate k and its direction number, then write back the sum once the
      // read data is registered, while the next dimension is being read.
      ST_POINT: begin
        if (can_issue) begin
          co_re      = 1'b1;
          dn_re      = 1'b1;
          s2_valid_d = 1'b1;
          s2_dim_d   = dim_q;
          dn_addr_d  = dn_addr_q + DN_AW'(FB);
          if (dim_q == DIM_LAST) begin
            iss_done_d = 1'b1;
          end else begin
            dim_d = dim_q + 1'b1;
          end
        end else if (s2_move) begin
          s2_valid_d = 1'b0;
        end
        if (s2_move) begin
          co_we = 1'b1;
          if (s2_emit) begin
            out_valid_d = 1'b1;
            out_dim_d   = 5'(s2_dim_q);
            out_coord_d = xor64[31:0];
            out_last_d  = s2_last;
            out_exh_d   = 1'b0;
          end
          if (iss_done_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      // Walk every row of every dimension and fold in the rows whose Gray
      // code bit is set.
      ST_SEEK: begin
        if (!iss_done_q) begin
          dn_re         = 1'b1;
          s2_valid_d    = 1'b1;
          s2_bit_d      = gray_q[row_q];
          s2_last_row_d = (row_q == ROW_LAST);
          s2_dim_d      = dim_q;
          dn_addr_d     = dn_addr_q + 1'b1;
          if (row_q == ROW_LAST) begin
            row_d = '0;
            if (dim_q == DIM_LAST) begin
              iss_done_d = 1'b1;
            end else begin
              dim_d = dim_q + 1'b1;
            end
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          s2_valid_d = 1'b0;
        end
        if (s2_valid_q) begin
          if (s2_last_row_q) begin
            co_we    = 1'b1;
            co_wdata = seek_val;
            acc_d    = '0;
            if (iss_done_q) begin
              state_d = ST_IDLE;
            end
          end else begin
            acc_d = seek_val;
          end
        end
      end

      ST_EXH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dim_d   = '0;
          out_coord_d = '0;
          out_last_d  = 1'b1;
          out_exh_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      dims_q      <= DIMS_RESET;
      row_q       <= '0;
      dim_q       <= '0;
      iss_done_q  <= 1'b0;
      dn_addr_q   <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dims_q      <= dims_d;
      row_q       <= row_d;
      dim_q       <= dim_d;
      iss_done_q  <= iss_done_d;
      dn_addr_q   <= dn_addr_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_dim_q      <= s2_dim_d;
    s2_bit_q      <= s2_bit_d;
    s2_last_row_q <= s2_last_row_d;
    acc_q         <= acc_d;
    gray_q        <= gray_d;
    win_q         <= win_d;
    out_dim_q     <= out_dim_d;
    out_coord_q   <= out_coord_d;
    out_last_q    <= out_last_d;
    out_exh_q     <= out_exh_d;
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.dimension  = out_dim_q;
  assign result_o.coordinate = out_coord_q;
  assign result_o.last       = out_last_q;
  assign result_o.exhausted  = out_exh_q;

endmodule

/* design/sobol_ram.sv */
module sobol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 18,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sobol_checker.sv */
module sobol_checker import sobol_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  out_dimension_i,
  input logic [31:0] out_coordinate_i,
  input logic        out_last_i,
  input logic        out_exhausted_i
);

  // An exhausted beat is a lone, empty, final beat.
  a_exh_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && out_exhausted_i |->
      out_last_i && out_dimension_i == 5'd0 && out_coordinate_i == 32'd0)
    else $error("exhausted beat malformed");

  // Only one item is in work at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_coordinate_i) && $stable(out_dimension_i) &&
      $stable(out_last_i))
    else $error("stalled beat changed");

  // Only the final coordinate of a full table can reach the top dimension.
  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_last_i |-> out_dimension_i < 5'(TABLE_DIMS - 1))
    else $error("non-final beat carries top dimension");

endmodule

bind sobol_sequence_generator sobol_checker u_sobol_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (item_i.valid),
  .in_ready_i      (item_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_dimension_i (result_o.dimension),
  .out_coordinate_i(result_o.coordinate),
  .out_last_i      (result_o.last),
  .out_exhausted_i (result_o.exhausted)
);
